@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ rtl/core/bba_pkg.sv @@
// Package: constants, types and helpers of the buddy allocator
package bba_pkg;
	localparam int unsigned LEAVES_DEF = 1024;
	localparam int unsigned MIN_BLOCK_DEF = 8;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_NOTUSED = 2'd3;

	// config register byte addresses
	localparam logic [1:0] REG_POOL_BASE = 2'd0;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned REQ_W    = 20;
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SIZE_W   = 14;
	localparam int unsigned CODE_W   = 5;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [REQ_W-1:0]    request_size;
		logic [ADDR_W-1:0]   address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   block_address;
		logic [SIZE_W-1:0]   block_size;
	} rsp_t;
endpackage

@@ rtl/core/bba_if.sv @@
// Valid/ready channel interfaces for requests and responses
interface bba_req_if import bba_pkg::*; ();
	logic valid;
	logic ready;
	logic [ACTION_W-1:0] action;
	logic [REQ_W-1:0]    request_size;
	logic [ADDR_W-1:0]   address;
	modport source (output valid, action, request_size, address, input ready);
	modport sink (input valid, action, request_size, address, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [ADDR_W-1:0]   block_address;
	logic [SIZE_W-1:0]   block_size;
	modport source (output valid, status, block_address, block_size, input ready);
	modport sink (input valid, status, block_address, block_size, output ready);
endinterface

@@ rtl/core/bba_tree_mem.sv @@
// Free-tree node memory: one write port, one registered read port
module bba_tree_mem import bba_pkg::*; #(
	parameter int unsigned NODES = 2 * LEAVES_DEF - 1,
	parameter int unsigned AW    = $clog2(NODES)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CODE_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [CODE_W-1:0] rdata
);
	logic [CODE_W-1:0] mem [NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/buddy_block_allocator.sv @@
// Top level: buddy block allocator with sequencer, tree memory and APB config
//
//  channel  | dir | handshake        | payload
//  req      | in  | valid/ready      | action, request_size, address
//  rsp      | out | valid/ready      | status, block_address, block_size
//  apb      | in  | psel/penable     | pool_base at byte address 0
//
// Reset starts a clearing pass that loads every node with its full level code;
// no transaction is taken meanwhile.
// The tree memory has one registered read port, so an allocate's descent reads
// each level before checking it, and each ancestor update reads the left child,
// reads the right child, then writes the combined code. Frees and queries climb
// from the leaf reading each node; a free then updates the ancestors as well.
// Ready drops while a transaction runs or its response waits to be taken.
module buddy_block_allocator import bba_pkg::*; #(
	parameter int unsigned LEAVES    = LEAVES_DEF,
	parameter int unsigned MIN_BLOCK = MIN_BLOCK_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bba_req_if.sink    req,
	bba_rsp_if.source  rsp,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready
);
`include "assert_macros.svh"
	localparam int unsigned LVL   = $clog2(LEAVES);
	localparam int unsigned NODES = 2 * LEAVES - 1;
	localparam int unsigned AW    = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int unsigned MB_SH = $clog2(MIN_BLOCK);
	localparam int unsigned POOL  = LEAVES * MIN_BLOCK;
	localparam logic [CODE_W-1:0] TOP = CODE_W'(LVL + 1);

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_START  = 4'd2;
	localparam logic [3:0] S_DRD    = 4'd3;  // read left child on descent
	localparam logic [3:0] S_DCHK   = 4'd4;
	localparam logic [3:0] S_FRD    = 4'd5;  // climb reading for used node
	localparam logic [3:0] S_FCHK   = 4'd6;
	localparam logic [3:0] S_URDL   = 4'd7;  // ancestor update: read left
	localparam logic [3:0] S_URDR   = 4'd8;  // read right
	localparam logic [3:0] S_UWR    = 4'd9;  // combine and write
	localparam logic [3:0] S_RESP   = 4'd10;
	localparam logic [3:0] S_RTCHK  = 4'd11; // alloc: check root

	logic [3:0]        state_q;
	logic [31:0]       base_q;
	logic [AW-1:0]     node_q;
	logic [CODE_W-1:0] code_q, need_q, left_q;
	logic [ACTION_W-1:0] act_q;
	logic [31:0]       addr_q;
	logic              frees_q;
	logic [CODE_W-1:0] clr_code_q;
	logic [AW-1:0]     clr_lvl_end_q;
	rsp_t              rsp_q;
	logic              rsp_v_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [CODE_W-1:0] wdata, rdata;

	bba_tree_mem #(.NODES(NODES), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_POOL_BASE) ? base_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_POOL_BASE) begin
			base_q <= pwdata;
		end
	end

	// request size to level code: smallest c with MIN_BLOCK<<(c-1) >= size
	logic [CODE_W-1:0] need_c;
	always_comb begin
		need_c = CODE_W'(LVL + 2);
		for (int c = LVL + 1; c >= 1; c--) begin
			if (33'(req.request_size) <= (33'(MIN_BLOCK) << (c - 1))) begin
				need_c = CODE_W'(c);
			end
		end
	end

	logic [31:0] offs;
	assign offs = addr_q - base_q;

	logic [AW-1:0] parent, left_ch;
	assign parent  = AW'((node_q - AW'(1)) >> 1);
	assign left_ch = AW'({node_q, 1'b1});

	// block offset of node at level code: (node+1-(LEAVES>>(code-1))) << (code-1+MB_SH)
	logic [31:0] blk_off, blk_size;
	assign blk_off  = (32'(node_q) + 32'd1 - (32'(LEAVES) >> (code_q - 1)))
		<< (32'(code_q) - 32'd1 + 32'(MB_SH));
	assign blk_size = 32'(MIN_BLOCK) << (code_q - 1);

	logic [CODE_W-1:0] mx;
	assign mx = (left_q > rdata) ? left_q : rdata;

	assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.status = rsp_q.status;
	assign rsp.block_address = rsp_q.block_address;
	assign rsp.block_size = rsp_q.block_size;

	always_comb begin
		we = 1'b0;
		waddr = node_q;
		wdata = '0;
		raddr = node_q;
		case (state_q)
			S_CLR: begin
				we = 1'b1;
				wdata = clr_code_q;
			end
			S_START: raddr = '0;
			S_DRD: raddr = left_ch;
			// chosen node marked used before its ancestors are read
			S_DCHK: begin
				if (code_q <= need_q) begin
					we = 1'b1;
					wdata = '0;
				end
			end
			// freed node gets its level code back
			S_FCHK: begin
				if (rdata == '0 && act_q == ACT_FREE) begin
					we = 1'b1;
					wdata = code_q;
				end
			end
			S_URDL: raddr = left_ch;
			S_URDR: raddr = AW'(left_ch + AW'(1));
			S_UWR: begin
				we = 1'b1;
				wdata = (frees_q && left_q == code_q - 1 && rdata == code_q - 1) ?
					code_q : mx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			node_q <= '0;
			clr_code_q <= TOP;
			clr_lvl_end_q <= '0;
			rsp_v_q <= 1'b0;
			rsp_q <= '0;
			code_q <= '0;
			need_q <= '0;
			left_q <= '0;
			act_q <= '0;
			addr_q <= '0;
			frees_q <= 1'b0;
		end else begin
			if (rsp_v_q && rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (32'(node_q) == NODES - 1) begin
						state_q <= S_IDLE;
					end else begin
						if (node_q == clr_lvl_end_q) begin
							clr_code_q <= clr_code_q - 1'b1;
							clr_lvl_end_q <= AW'({clr_lvl_end_q, 1'b0} + 1'b1 + 1'b1);
						end
						node_q <= node_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req.valid && !rsp_v_q) begin
						act_q <= req.action;
						addr_q <= req.address;
						need_q <= need_c;
						node_q <= '0;
						code_q <= TOP;
						rsp_q <= '0;
						state_q <= S_START;
					end
				end
				S_START: begin
					if (act_q == ACT_ALLOC) begin
						state_q <= S_RTCHK;
					end else if (act_q == ACT_FREE || act_q == ACT_QUERY) begin
						if (offs >= 32'(POOL)) begin
							rsp_q.status <= ST_RANGE;
							state_q <= S_RESP;
						end else begin
							node_q <= AW'((offs >> MB_SH) + (LEAVES - 1));
							code_q <= CODE_W'(1);
							state_q <= S_FRD;
						end
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RTCHK: begin
					if (need_q > TOP || rdata < need_q) begin
						rsp_q.status <= ST_NOSPACE;
						state_q <= S_RESP;
					end else if (code_q > need_q) begin
						state_q <= S_DRD;
					end else begin
						state_q <= S_DCHK;
					end
				end
				S_DRD: state_q <= S_DCHK;
				S_DCHK: begin
					if (code_q > need_q) begin
						node_q <= (rdata >= need_q) ? left_ch : AW'(left_ch + AW'(1));
						code_q <= code_q - 1'b1;
						state_q <= (code_q - 1'b1 > need_q) ? S_DRD : S_DCHK;
					end else begin
						// chosen node: mark used, report
						rsp_q.block_address <= blk_off + base_q;
						rsp_q.block_size <= SIZE_W'(blk_size);
						frees_q <= 1'b0;
						state_q <= (node_q == '0) ? S_RESP : S_URDL;
						node_q <= (node_q == '0) ? node_q : parent;
						code_q <= code_q + 1'b1;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (rdata != '0) begin
						if (node_q == '0) begin
							rsp_q.status <= ST_NOTUSED;
							state_q <= S_RESP;
						end else begin
							node_q <= parent;
							code_q <= code_q + 1'b1;
							state_q <= S_FRD;
						end
					end else begin
						rsp_q.block_size <= SIZE_W'(blk_size);
						if (act_q == ACT_FREE) begin
							frees_q <= 1'b1;
							state_q <= (node_q == '0) ? S_RESP : S_URDL;
							node_q <= (node_q == '0) ? node_q : parent;
							code_q <= code_q + 1'b1;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_URDL: state_q <= S_URDR;
				S_URDR: begin
					left_q <= rdata;
					state_q <= S_UWR;
				end
				S_UWR: begin
					if (node_q == '0) begin
						state_q <= S_RESP;
					end else begin
						node_q <= parent;
						code_q <= code_q + 1'b1;
						state_q <= S_URDL;
					end
				end
				S_RESP: begin
					rsp_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, req.ready, state_q == S_IDLE, "ready outside idle")
	`ASSERT_NEXT(a_rsp_after, clk, arst_n, state_q == S_RESP, rsp_v_q, "response not raised")
	`ASSERT_IMPL(a_no_take_busy, clk, arst_n, rsp_v_q, !req.ready, "took request while rsp held")
endmodule
